### rtl/ow_pkg.sv
// ----------------------------------------------------------------------------
// ow_pkg
// shared types and constants of the one-wire temperature reader
// ----------------------------------------------------------------------------
`default_nettype none

package ow_pkg;

    localparam int unsigned TICK_W         = 10;
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned TEMP_W         = 15;
    localparam int unsigned READ_BYTES_DEF = 9;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    localparam logic [CFG_ADDR_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RESET_REC     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_SLOT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_SLOT     = 3'd4;

    localparam logic [TICK_W-1:0] RESET_LOW_DEF     = 10'd500;
    localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEF = 10'd70;
    localparam logic [TICK_W-1:0] RESET_REC_DEF     = 10'd500;
    localparam logic [TICK_W-1:0] SHORT_SLOT_DEF    = 10'd7;
    localparam logic [TICK_W-1:0] LONG_SLOT_DEF     = 10'd70;

    typedef enum logic [13:0] {
        ST_IDLE        = 14'b00000000000001,
        ST_R1_LOW      = 14'b00000000000010,
        ST_R1_WAIT     = 14'b00000000000100,
        ST_R1_REC_OK   = 14'b00000000001000,
        ST_R1_REC_FAIL = 14'b00000000010000,
        ST_W_CC1       = 14'b00000000100000,
        ST_W_44        = 14'b00000001000000,
        ST_WAIT_HIGH   = 14'b00000010000000,
        ST_R2_LOW      = 14'b00000100000000,
        ST_R2_WAIT     = 14'b00001000000000,
        ST_R2_REC      = 14'b00010000000000,
        ST_W_CC2       = 14'b00100000000000,
        ST_W_BE        = 14'b01000000000000,
        ST_READ        = 14'b10000000000000
    } t_step;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] presence_wait;
        logic [TICK_W-1:0] reset_rec;
        logic [TICK_W-1:0] short_slot;
        logic [TICK_W-1:0] long_slot;
    } t_cfg;

    typedef struct packed {
        logic              drive_low;
        logic              busy;
        logic              done;
        logic              presence_error;
        logic [TEMP_W-1:0] temperature;
    } t_res;

endpackage

`default_nettype wire

### rtl/ow_cfg.sv
// ----------------------------------------------------------------------------
// ow_cfg
// timing registers written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module ow_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [ow_pkg::CFG_ADDR_W-1:0] i_addr,
    input  wire logic [ow_pkg::TICK_W-1:0]     i_data,
    output ow_pkg::t_cfg                       o_cfg
);
    import ow_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RESET_LOW_DEF;
            r_cfg.presence_wait <= PRESENCE_WAIT_DEF;
            r_cfg.reset_rec     <= RESET_REC_DEF;
            r_cfg.short_slot    <= SHORT_SLOT_DEF;
            r_cfg.long_slot     <= LONG_SLOT_DEF;
        end else if (i_wr) begin
            case (i_addr)
                REG_RESET_LOW:     r_cfg.reset_low     <= i_data;
                REG_PRESENCE_WAIT: r_cfg.presence_wait <= i_data;
                REG_RESET_REC:     r_cfg.reset_rec     <= i_data;
                REG_SHORT_SLOT:    r_cfg.short_slot    <= i_data;
                REG_LONG_SLOT:     r_cfg.long_slot     <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/ow_seq.sv
// ----------------------------------------------------------------------------
// ow_seq
// bus sequencer: reset, command writes, conversion wait and scratchpad read
// ----------------------------------------------------------------------------
`default_nettype none

module ow_seq #(
    parameter int unsigned READ_BYTES = ow_pkg::READ_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire logic         i_mode,
    input  wire logic         i_line,
    input  wire ow_pkg::t_cfg i_cfg,
    output ow_pkg::t_res      o_res
);
    import ow_pkg::*;

    localparam logic [3:0] LAST_BYTE = READ_BYTES[3:0];

    t_step             r_step,   n_step;
    logic [1:0]        r_phase,  n_phase;
    logic [2:0]        r_bit,    n_bit;
    logic [3:0]        r_byte,   n_byte;
    logic [7:0]        r_shift,  n_shift;
    logic [TICK_W-1:0] r_tick,   n_tick;
    logic [7:0]        r_low,    n_low;
    logic [TEMP_W-1:0] r_result, n_result;
    logic              r_pull,   n_pull;
    logic              done, err;
    logic [7:0]        sh_next;
    logic [2:0]        bit_next;
    logic [3:0]        byte_next;

    always_comb begin
        n_step   = r_step;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_tick   = r_tick;
        n_low    = r_low;
        n_result = r_result;
        n_pull   = r_pull;
        done     = 1'b0;
        err      = 1'b0;
        sh_next  = {1'b0, r_shift[7:1]};
        bit_next = r_bit + 3'd1;
        byte_next = r_byte + 4'd1;

        if (i_mode) begin
            if (r_step == ST_IDLE) begin
                n_result = '0;
                n_low    = '0;
                n_byte   = '0;
                n_bit    = '0;
                n_phase  = '0;
                n_shift  = '0;
                n_step   = ST_R1_LOW;
                n_pull   = 1'b1;
                n_tick   = i_cfg.reset_low;
            end
        end else if (r_step == ST_WAIT_HIGH) begin
            if (i_line) begin
                n_step = ST_R2_LOW;
                n_pull = 1'b1;
                n_tick = i_cfg.reset_low;
            end
        end else if (r_step != ST_IDLE) begin
            if (r_tick > 10'd1) begin
                n_tick = r_tick - 10'd1;
            end else begin
                case (r_step)
                    ST_R1_LOW, ST_R2_LOW: begin
                        n_pull = 1'b0;
                        n_step = (r_step == ST_R1_LOW) ? ST_R1_WAIT : ST_R2_WAIT;
                        n_tick = i_cfg.presence_wait;
                    end
                    ST_R1_WAIT: begin
                        n_pull = 1'b0;
                        n_step = i_line ? ST_R1_REC_FAIL : ST_R1_REC_OK;
                        n_tick = i_cfg.reset_rec;
                    end
                    ST_R2_WAIT: begin
                        n_pull = 1'b0;
                        n_step = ST_R2_REC;
                        n_tick = i_cfg.reset_rec;
                    end
                    ST_R1_REC_OK, ST_R2_REC: begin
                        n_step  = (r_step == ST_R1_REC_OK) ? ST_W_CC1 : ST_W_CC2;
                        n_shift = CMD_SKIP_ROM;
                        n_bit   = '0;
                        n_phase = '0;
                        n_pull  = 1'b1;
                        n_tick  = CMD_SKIP_ROM[0] ? i_cfg.short_slot : i_cfg.long_slot;
                    end
                    ST_R1_REC_FAIL: begin
                        n_step = ST_IDLE;
                        n_pull = 1'b0;
                        done   = 1'b1;
                        err    = 1'b1;
                    end
                    ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE: begin
                        if (r_phase == 2'd0) begin
                            n_pull  = 1'b0;
                            n_phase = 2'd1;
                            n_tick  = r_shift[0] ? i_cfg.long_slot : i_cfg.short_slot;
                        end else begin
                            n_shift = sh_next;
                            n_bit   = bit_next;
                            if (bit_next == 3'd0) begin
                                case (r_step)
                                    ST_W_CC1, ST_W_CC2: begin
                                        n_step  = (r_step == ST_W_CC1) ? ST_W_44 : ST_W_BE;
                                        n_shift = (r_step == ST_W_CC1) ? CMD_CONVERT
                                                                       : CMD_READ_SP;
                                        n_phase = '0;
                                        n_pull  = 1'b1;
                                        n_tick  = n_shift[0] ? i_cfg.short_slot
                                                             : i_cfg.long_slot;
                                    end
                                    ST_W_44: begin
                                        n_step = ST_WAIT_HIGH;
                                        n_pull = 1'b0;
                                    end
                                    default: begin
                                        n_byte  = '0;
                                        n_step  = ST_READ;
                                        n_shift = '0;
                                        n_phase = '0;
                                        n_pull  = 1'b1;
                                        n_tick  = i_cfg.short_slot;
                                    end
                                endcase
                            end else begin
                                n_phase = '0;
                                n_pull  = 1'b1;
                                n_tick  = sh_next[0] ? i_cfg.short_slot : i_cfg.long_slot;
                            end
                        end
                    end
                    ST_READ: begin
                        if (r_phase == 2'd0) begin
                            n_pull  = 1'b0;
                            n_phase = 2'd1;
                            n_tick  = i_cfg.short_slot;
                        end else if (r_phase == 2'd1) begin
                            n_shift = {i_line, r_shift[7:1]};
                            n_phase = 2'd2;
                            n_tick  = i_cfg.long_slot;
                        end else begin
                            n_bit = bit_next;
                            if (bit_next != 3'd0) begin
                                n_phase = '0;
                                n_pull  = 1'b1;
                                n_tick  = i_cfg.short_slot;
                            end else begin
                                if (r_byte == 4'd0) begin
                                    n_low = r_shift;
                                end
                                if (r_byte == 4'd1) begin
                                    n_result = {r_shift, r_low[7:1]};
                                end
                                n_byte = byte_next;
                                if (byte_next >= LAST_BYTE) begin
                                    n_step  = ST_IDLE;
                                    n_phase = '0;
                                    n_pull  = 1'b0;
                                    done    = 1'b1;
                                end else begin
                                    n_step  = ST_READ;
                                    n_shift = '0;
                                    n_bit   = '0;
                                    n_phase = '0;
                                    n_pull  = 1'b1;
                                    n_tick  = i_cfg.short_slot;
                                end
                            end
                        end
                    end
                    default: begin
                        n_step = ST_IDLE;
                        n_pull = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_phase  <= '0;
            r_bit    <= '0;
            r_byte   <= '0;
            r_shift  <= '0;
            r_tick   <= '0;
            r_low    <= '0;
            r_result <= '0;
            r_pull   <= 1'b0;
        end else if (i_fire) begin
            r_step   <= n_step;
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_byte   <= n_byte;
            r_shift  <= n_shift;
            r_tick   <= n_tick;
            r_low    <= n_low;
            r_result <= n_result;
            r_pull   <= n_pull;
        end
    end

    assign o_res.drive_low      = n_pull;
    assign o_res.busy           = (n_step != ST_IDLE);
    assign o_res.done           = done;
    assign o_res.presence_error = err;
    assign o_res.temperature    = n_result;

endmodule

`default_nettype wire

### rtl/one_wire_temperature_reader_top.sv
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_top: 1-wire master running a temperature read
// an input transfer is held in the input regs, and its result in the result regs
// throughput one item per cycle while results are taken; sequencer state updates per item
// synchronous active-low reset: idle, line released, timing registers default
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_temperature_reader_top #(
    parameter int unsigned READ_BYTES = ow_pkg::READ_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output      logic                          o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,  // [0] line_level
    input  wire logic [0:0]                    i_s_tuser,  // [0] mode
    output      logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    output      logic [23:0]                   o_m_tdata,  // [0] drive_low, [1] busy_res,
                                                           // [2] presence_error,
                                                           // [17:3] temperature
    output      logic                          o_m_tlast,  // done_res
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [ow_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ow_pkg::TICK_W-1:0]     i_cfg_data
);
    import ow_pkg::*;

    t_cfg  cfg;
    t_res  res;
    logic  r_in_valid;
    logic  r_in_mode;
    logic  r_in_line;
    logic  r_out_valid;
    t_res  r_out;
    logic  fire;

    assign o_cfg_ready = 1'b1;

    ow_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign fire       = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode <= i_s_tuser[0];
            r_in_line <= i_s_tdata[0];
        end
    end

    ow_seq #(
        .READ_BYTES (READ_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_mode  (r_in_mode),
        .i_line  (r_in_line),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.done;
    assign o_m_tdata  = {6'd0, r_out.temperature, r_out.presence_error,
                         r_out.busy, r_out.drive_low};

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: one-wire temperature reader
// drives tick and start items with line levels shaped by a cycle-level
// prediction of the sequencer, so that most runs get through presence,
// the command writes and the scratchpad read. each result transfer is
// compared field by field with the predicted reading. timing registers
// are rewritten between measurements, mostly from zero up to two, with
// one run on a longer reset pulse and presence wait.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ow_pkg::*;

    localparam int unsigned SCRATCH_BYTES  = READ_BYTES_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum {PAT_RANDOM, PAT_ONES, PAT_ZEROS} t_read_pattern;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;   // [0] line_level
    logic [0:0]            i_s_tuser;   // [0] mode
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [23:0]           o_m_tdata;   // [0] drive_low, [1] busy_res, [2] presence_error,
                                        // [17:3] temperature
    logic                  o_m_tlast;   // done_res
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [TICK_W-1:0]     i_cfg_data;

    one_wire_temperature_reader_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted sequencer state
    t_cfg              timing;
    t_step             seq_step;
    logic [2:0]        slot_ph;
    logic [2:0]        bit_no;
    logic [3:0]        byte_no;
    logic [7:0]        shift_q;
    logic [TICK_W-1:0] ticks_left;
    logic [7:0]        first_byte;
    logic [TEMP_W-1:0] temp_q;
    logic              pull_q;

    t_res          expected_readings[$];
    t_res          exp_res;
    int unsigned   fail_count;
    int unsigned   items_done;
    int unsigned   stall_cycles;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    bit            presence_ok;
    t_read_pattern read_pattern;

    always #4 i_clk = ~i_clk;

    function automatic void reset_reader_model();
        timing.reset_low     = RESET_LOW_DEF;
        timing.presence_wait = PRESENCE_WAIT_DEF;
        timing.reset_rec     = RESET_REC_DEF;
        timing.short_slot    = SHORT_SLOT_DEF;
        timing.long_slot     = LONG_SLOT_DEF;
        seq_step   = ST_IDLE;
        slot_ph    = '0;
        bit_no     = '0;
        byte_no    = '0;
        shift_q    = '0;
        ticks_left = '0;
        first_byte = '0;
        temp_q     = '0;
        pull_q     = 1'b0;
    endfunction

    function automatic void begin_write_byte(input t_step nxt_step, input logic [7:0] value);
        seq_step   = nxt_step;
        shift_q    = value;
        bit_no     = '0;
        slot_ph    = '0;
        pull_q     = 1'b1;
        ticks_left = value[0] ? timing.short_slot : timing.long_slot;
    endfunction

    function automatic void begin_read_byte();
        seq_step   = ST_READ;
        shift_q    = '0;
        bit_no     = '0;
        slot_ph    = '0;
        pull_q     = 1'b1;
        ticks_left = timing.short_slot;
    endfunction

    function automatic void begin_reset_pulse(input t_step nxt_step);
        seq_step   = nxt_step;
        pull_q     = 1'b1;
        ticks_left = timing.reset_low;
    endfunction

    function automatic void end_write_slot();
        if (slot_ph == 0) begin
            pull_q     = 1'b0;
            slot_ph    = 3'd1;
            ticks_left = shift_q[0] ? timing.long_slot : timing.short_slot;
            return;
        end
        shift_q = shift_q >> 1;
        bit_no  = bit_no + 3'd1;
        if (bit_no == 0) begin
            case (seq_step)
                ST_W_CC1: begin
                    begin_write_byte(ST_W_44, CMD_CONVERT);
                end
                ST_W_44: begin
                    seq_step = ST_WAIT_HIGH;
                    pull_q   = 1'b0;
                end
                ST_W_CC2: begin
                    begin_write_byte(ST_W_BE, CMD_READ_SP);
                end
                default: begin
                    byte_no = '0;
                    begin_read_byte();
                end
            endcase
            return;
        end
        slot_ph    = '0;
        pull_q     = 1'b1;
        ticks_left = shift_q[0] ? timing.short_slot : timing.long_slot;
    endfunction

    // returns 1 when the last scratchpad byte has been read
    function automatic logic end_read_slot(input logic line);
        logic [15:0] joined;
        if (slot_ph == 0) begin
            pull_q     = 1'b0;
            slot_ph    = 3'd1;
            ticks_left = timing.short_slot;
            return 1'b0;
        end
        if (slot_ph == 1) begin
            shift_q    = {line, shift_q[7:1]};
            slot_ph    = 3'd2;
            ticks_left = timing.long_slot;
            return 1'b0;
        end
        bit_no = bit_no + 3'd1;
        if (bit_no != 0) begin
            slot_ph    = '0;
            pull_q     = 1'b1;
            ticks_left = timing.short_slot;
            return 1'b0;
        end
        if (byte_no == 0) first_byte = shift_q;
        if (byte_no == 1) begin
            joined = {shift_q, first_byte};
            temp_q = joined[15:1];
        end
        byte_no = byte_no + 4'd1;
        if (byte_no >= SCRATCH_BYTES) begin
            seq_step = ST_IDLE;
            slot_ph  = '0;
            pull_q   = 1'b0;
            return 1'b1;
        end
        begin_read_byte();
        return 1'b0;
    endfunction

    function automatic t_res predict_reading(input logic mode, input logic line);
        t_res res;
        logic done;
        logic no_presence;
        done        = 1'b0;
        no_presence = 1'b0;
        if (mode) begin
            if (seq_step == ST_IDLE) begin
                temp_q     = '0;
                first_byte = '0;
                byte_no    = '0;
                bit_no     = '0;
                slot_ph    = '0;
                shift_q    = '0;
                begin_reset_pulse(ST_R1_LOW);
            end
        end else if (seq_step == ST_WAIT_HIGH) begin
            if (line) begin_reset_pulse(ST_R2_LOW);
        end else if (seq_step != ST_IDLE) begin
            if (ticks_left > 1) begin
                ticks_left = ticks_left - 1'b1;
            end else begin
                case (seq_step)
                    ST_R1_LOW: begin
                        pull_q     = 1'b0;
                        seq_step   = ST_R1_WAIT;
                        ticks_left = timing.presence_wait;
                    end
                    ST_R1_WAIT: begin
                        pull_q     = 1'b0;
                        seq_step   = line ? ST_R1_REC_FAIL : ST_R1_REC_OK;
                        ticks_left = timing.reset_rec;
                    end
                    ST_R1_REC_OK: begin
                        begin_write_byte(ST_W_CC1, CMD_SKIP_ROM);
                    end
                    ST_R1_REC_FAIL: begin
                        seq_step    = ST_IDLE;
                        pull_q      = 1'b0;
                        done        = 1'b1;
                        no_presence = 1'b1;
                    end
                    ST_R2_LOW: begin
                        pull_q     = 1'b0;
                        seq_step   = ST_R2_WAIT;
                        ticks_left = timing.presence_wait;
                    end
                    ST_R2_WAIT: begin
                        pull_q     = 1'b0;
                        seq_step   = ST_R2_REC;
                        ticks_left = timing.reset_rec;
                    end
                    ST_R2_REC: begin
                        begin_write_byte(ST_W_CC2, CMD_SKIP_ROM);
                    end
                    ST_W_CC1, ST_W_44, ST_W_CC2, ST_W_BE: begin
                        end_write_slot();
                    end
                    ST_READ: begin
                        done = end_read_slot(line);
                    end
                    default: begin
                        seq_step = ST_IDLE;
                        pull_q   = 1'b0;
                    end
                endcase
            end
        end
        res.drive_low      = pull_q;
        res.busy           = (seq_step != ST_IDLE);
        res.done           = done;
        res.presence_error = no_presence;
        res.temperature    = temp_q;
        return res;
    endfunction

    // line level that steers the sequence: presence and read data as planned
    function automatic logic pick_line();
        if (seq_step == ST_R1_WAIT && ticks_left <= 1) return !presence_ok;
        if (seq_step == ST_READ && slot_ph == 1 && ticks_left <= 1) begin
            case (read_pattern)
                PAT_ONES:  return 1'b1;
                PAT_ZEROS: return 1'b0;
                default:   return 1'($urandom_range(1));
            endcase
        end
        if (seq_step == ST_WAIT_HIGH) return ($urandom_range(99) < 40);
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        if ($urandom_range(3) == 0) return '0;
        return TICK_W'($urandom_range(1, 2));
    endfunction

    function automatic void check_field(input string name, input logic [14:0] want,
                                        input logic [14:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(input logic mode, input logic line);
        bit counted;
        counted = mode ? (seq_step == ST_IDLE) : (seq_step != ST_IDLE);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, line};
        do @(posedge i_clk); while (!o_s_tready);
        expected_readings.push_back(predict_reading(mode, line));
        if (counted) items_done++;
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [TICK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            REG_RESET_LOW:     timing.reset_low     = value;
            REG_PRESENCE_WAIT: timing.presence_wait = value;
            REG_RESET_REC:     timing.reset_rec     = value;
            REG_SHORT_SLOT:    timing.short_slot    = value;
            REG_LONG_SLOT:     timing.long_slot     = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] reset_low, presence_wait, reset_rec,
                              short_slot, long_slot);
        wait_results();
        write_reg(REG_RESET_LOW, reset_low);
        write_reg(REG_PRESENCE_WAIT, presence_wait);
        write_reg(REG_RESET_REC, reset_rec);
        write_reg(REG_SHORT_SLOT, short_slot);
        write_reg(REG_LONG_SLOT, long_slot);
    endtask

    task automatic run_measurement(input int unsigned presence_pct);
        presence_ok = ($urandom_range(99) < presence_pct);
        case ($urandom_range(3))
            0:       read_pattern = PAT_ONES;
            1:       read_pattern = PAT_ZEROS;
            default: read_pattern = PAT_RANDOM;
        endcase
        send_item(1'b1, 1'($urandom_range(1)));
        while (seq_step != ST_IDLE) send_item($urandom_range(99) < 3, pick_line());
        repeat ($urandom_range(2)) send_item(1'b0, 1'($urandom_range(1)));
    endtask

    task automatic test_idle_ticks();
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        repeat (4) send_item(1'b0, 1'($urandom_range(1)));
    endtask

    // zero-tick reset pulse, start while busy, then no presence pulse
    task automatic test_missing_presence();
        set_timing('0, 10'd1, 10'd1, 10'd1, 10'd1);
        presence_ok = 1'b0;
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        while (seq_step != ST_IDLE) send_item(1'b0, pick_line());
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
    endtask

    task automatic test_random_measurements(input int unsigned target);
        int unsigned first;
        first = items_done;
        while (items_done - first < target) begin
            set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
            run_measurement(95);
        end
    endtask

    // long reset pulse and presence wait, ending without presence
    task automatic test_slow_timing();
        set_timing(10'd64, 10'd64, 10'd1, 10'd1, 10'd1);
        run_measurement(0);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: result transfer with no reading expected", $time);
                fail_count++;
            end else begin
                exp_res = expected_readings.pop_front();
                check_field("drive_low", exp_res.drive_low, o_m_tdata[0]);
                check_field("busy_res", exp_res.busy, o_m_tdata[1]);
                check_field("done_res", exp_res.done, o_m_tlast);
                check_field("presence_error", exp_res.presence_error, o_m_tdata[2]);
                check_field("temperature", exp_res.temperature, o_m_tdata[17:3]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_data     = '0;
        fail_count     = 0;
        items_done     = 0;
        stall_cycles   = 0;
        send_idle_pct  = 24;
        recv_stall_pct = 70;
        presence_ok    = 1'b1;
        read_pattern   = PAT_RANDOM;
        reset_reader_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_missing_presence();
        test_random_measurements(200);

        send_idle_pct  = 70;
        recv_stall_pct = 24;
        test_random_measurements(200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_measurements(200);
        test_slow_timing();

        wait_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
